FILE: src/kgr_pkg.sv
// Shared types and constants for the k-group reverser.
// No dependencies.
package kgr_pkg;

  localparam int VALUE_W = 32;
  localparam int GSIZE_W = 5;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [GSIZE_W-1:0]        gsize_t;

  localparam gsize_t GSIZE_RESET = 5'd2;

endpackage

FILE: src/kgr_buf.sv
// Group buffer: one write port, one registered read port with enable.
// Depends on kgr_pkg.
module kgr_buf
  import kgr_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  value_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output value_t        rd_data
);

  value_t mem [DEPTH];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read register doubles as the output word holder; holds while stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/k_group_reverser.sv
// k_group_reverser top level: buffers words into groups and replays them.
// Depends on kgr_pkg and kgr_buf.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, in_value, in_seq_end   | input
//  out     | out_valid, out_ready, out_value,           | output
//          | out_run_last, out_seq_end                  |
//  cfg     | cfg_wr_en, cfg_wr_data (group size)        | input
//
// While a group fills, one input word is taken per cycle. When a
// group completes (or the sequence ends) the block drains n words from the
// buffer memory, one read per cycle unless the output stalls, through its
// single read port, and takes no input until the drain is done. Reset
// clears the fill count, the sequencer and the output valid and sets the
// group size to GSIZE_RESET; buffer contents are left as they are. An output
// stall holds the read register and pauses the drain.
module k_group_reverser
  import kgr_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_valid,
  output logic         in_ready,
  input  value_t       in_value,
  input  logic         in_seq_end,
  // result channel
  output logic         out_valid,
  input  logic         out_ready,
  output value_t       out_value,
  output logic         out_run_last,
  output logic         out_seq_end,
  // configuration
  input  logic         cfg_wr_en,
  input  gsize_t       cfg_wr_data
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);       // holds 0..MAX_GROUP
  localparam int KW = (CW > GSIZE_W) ? CW : GSIZE_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state_r, state_nxt;
  gsize_t        gsize_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] rem_r, rem_nxt;      // words still to read in this drain
  logic [AW-1:0] addr_r, addr_nxt;
  logic          dir_r, dir_nxt;      // 1: reversed, walk down
  logic          seq_r, seq_nxt;      // drain was caused by a sequence end
  logic          out_valid_r, out_valid_nxt;
  logic          last_r, last_nxt;
  logic          oseq_r, oseq_nxt;

  logic          in_acc;
  logic          rd_en;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] n_ext;
  logic [CW-1:0] n_cnt;
  logic          full_grp;

  // effective group size: zero counts as one, large values saturate
  always_comb begin
    if (gsize_r == '0) begin
      k_eff = KW'(1);
    end else if (KW'(gsize_r) > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = KW'(gsize_r);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign n_cnt    = fill_r + CW'(1);     // fill after this word is stored
  assign n_ext    = KW'(n_cnt);
  assign full_grp = (n_ext >= k_eff);

  // issue a read when the output register is free or emptying this cycle
  assign rd_en = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    dir_nxt       = dir_r;
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    oseq_nxt      = oseq_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (full_grp || in_seq_end) begin
            state_nxt = ST_DRAIN;
            fill_nxt  = '0;
            rem_nxt   = n_cnt;
            dir_nxt   = full_grp;
            // reversed starts at the newest word, at index fill_r
            addr_nxt  = full_grp ? fill_r[AW-1:0] : '0;
            seq_nxt   = in_seq_end;
          end else begin
            fill_nxt = n_cnt;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_en) begin
          out_valid_nxt = 1'b1;
          last_nxt      = (rem_r == CW'(1));
          oseq_nxt      = seq_r && (rem_r == CW'(1));
          rem_nxt       = rem_r - CW'(1);
          addr_nxt      = dir_r ? (addr_r - AW'(1)) : (addr_r + AW'(1));
          if (rem_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gsize_r     <= GSIZE_RESET;
      fill_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        gsize_r <= cfg_wr_data;
      end
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    dir_r  <= dir_nxt;
    seq_r  <= seq_nxt;
    last_r <= last_nxt;
    oseq_r <= oseq_nxt;
  end

  kgr_buf #(
    .DEPTH (MAX_GROUP),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (out_value)
  );

  assign out_valid    = out_valid_r;
  assign out_run_last = last_r;
  assign out_seq_end  = oseq_r;

  // fill count never reaches the buffer depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CW'(MAX_GROUP))
    else $error("fill count reached buffer depth");

  // a drain always has at least one word left to read
  a_drain_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> rem_r != '0)
    else $error("drain with nothing left");

  // sequence end only flags the final word of a group
  a_seq_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seq_end |-> out_run_last)
    else $error("sequence end without run last");

  // a completed group or a sequence end starts a drain on the next cycle
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (full_grp || in_seq_end) |=> state_r == ST_DRAIN && fill_r == '0)
    else $error("group completion did not start drain");

endmodule
